### design/rgbpg_pkg.sv
`default_nettype none
package rgbpg_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [9:0] LUMA_R     = 10'd306;
    localparam logic [9:0] LUMA_G     = 10'd601;
    localparam logic [9:0] LUMA_B     = 10'd117;
    localparam int         LUMA_SHIFT = 10;
    localparam logic [7:0] FULL       = 8'd255;

    // register index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_GRAY_MODE  = 2'd0,
        REG_SRC_ALPHA  = 2'd1,
        REG_COLOR_KEY  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic        gray_mode;
        logic        source_has_alpha;
        logic [31:0] color_key;
    } t_cfg;

    // c*a/255 truncated; exact for products below 65535
    function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
        logic [15:0] p;
        logic [16:0] q;
        p = c * a;
        q = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
        return q[15:8];
    endfunction

endpackage
`default_nettype wire

### design/rgbpg_if.sv
`default_nettype none
interface rgbpg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       last_pixel;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, last_pixel,
                    input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, last_pixel,
                    output ready);
endinterface

interface rgbpg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic [7:0] alpha_out;
    logic       alpha_used;
    logic       image_done;

    modport source (output valid, blue_out, green_out, red_out, alpha_out, alpha_used,
                    image_done, input ready);
    modport sink   (input valid, blue_out, green_out, red_out, alpha_out, alpha_used,
                    image_done, output ready);
endinterface
`default_nettype wire

### design/rgbpg_regs.sv
`default_nettype none
module rgbpg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rgbpg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rgbpg_pkg::DATA_W-1:0] pwdata,
    output      logic [rgbpg_pkg::DATA_W-1:0] prdata,
    output      logic                         pready,
    output      rgbpg_pkg::t_cfg              o_cfg
);
    import rgbpg_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            case (idx)
                REG_GRAY_MODE: r_cfg.gray_mode        <= pwdata[0];
                REG_SRC_ALPHA: r_cfg.source_has_alpha <= pwdata[0];
                REG_COLOR_KEY: r_cfg.color_key        <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GRAY_MODE: prdata = {31'b0, r_cfg.gray_mode};
            REG_SRC_ALPHA: prdata = {31'b0, r_cfg.source_has_alpha};
            REG_COLOR_KEY: prdata = r_cfg.color_key;
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

### design/rgba_premultiply_gray_colorkey_top.sv
`default_nettype none
// RGBA pixel to BGRA pixel converter with alpha premultiply, luma gray and
// color keying.
//
// Channels: in_ch (sink) takes one RGBA pixel plus last_pixel per transfer;
// out_ch (source) gives one BGRA pixel plus alpha_used / image_done per
// transfer. Both are valid/ready; a transfer happens when both are high.
// Config: APB-style port, registers at 0x0 gray_mode, 0x4 source_has_alpha,
// 0x8 color_key. pready is tied high; write only while the stream is idle.
//
// Pipeline: input register, premultiply register and result register, in that
// order, lie between an input transfer and its result on out_ch.
// Throughput: one pixel per clock while out_ch.ready stays high, since every
// stage loads in any cycle where the stage ahead is empty or moving on.
//
// Reset (synchronous, active low) clears the config registers, all stage
// valid bits and the sticky per-image flag.
//
// Stall: when out_ch.ready is low, the pipeline fills up; each stage holds
// while the stage ahead is full and blocked, so in_ch.ready drops only
// once all three stages hold a pixel. Bubbles are squeezed out.
module rgba_premultiply_gray_colorkey_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rgbpg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rgbpg_pkg::DATA_W-1:0] pwdata,
    output      logic [rgbpg_pkg::DATA_W-1:0] prdata,
    output      logic                         pready,
    rgbpg_in_if.sink                          in_ch,
    rgbpg_out_if.source                       out_ch
);
    import rgbpg_pkg::*;

    t_cfg cfg;

    rgbpg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // stage control
    logic r_v0, r_v1, r_v2;
    logic adv0, adv1, adv2;

    assign adv2 = !r_v2 || out_ch.ready;   // result reg can load
    assign adv1 = !r_v1 || adv2;           // premul reg can load
    assign adv0 = !r_v0 || adv1;           // input reg can load

    assign in_ch.ready = adv0;

    // stage 0: input register
    logic [7:0] r_r0, r_g0, r_b0, r_a0;
    logic       r_l0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv0) begin
            r_v0 <= in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0 && in_ch.valid) begin
            r_r0 <= in_ch.red_in;
            r_g0 <= in_ch.green_in;
            r_b0 <= in_ch.blue_in;
            r_a0 <= in_ch.alpha_in;
            r_l0 <= in_ch.last_pixel;
        end
    end

    // stage 1: premultiply
    logic       do_pm;
    logic [7:0] n_r1, n_g1, n_b1;
    logic [7:0] r_r1, r_g1, r_b1, r_a1;
    logic       r_l1, r_pm1;

    assign do_pm = cfg.source_has_alpha && (r_a0 != FULL);

    always_comb begin
        n_r1 = do_pm ? premul(r_r0, r_a0) : r_r0;
        n_g1 = do_pm ? premul(r_g0, r_a0) : r_g0;
        n_b1 = do_pm ? premul(r_b0, r_a0) : r_b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && r_v0) begin
            r_r1  <= n_r1;
            r_g1  <= n_g1;
            r_b1  <= n_b1;
            r_a1  <= r_a0;
            r_l1  <= r_l0;
            r_pm1 <= do_pm;
        end
    end

    // stage 2: luma gray, color key, sticky flag
    logic [17:0] luma_sum;
    logic [7:0]  y, n_r, n_g, n_b;
    logic [31:0] packed_px;
    logic        key_hit, used;
    logic        r_seen;
    logic [7:0]  r_bo, r_go, r_ro, r_ao;
    logic        r_used, r_done;

    always_comb begin
        luma_sum = 18'(r_r1) * 18'(LUMA_R) + 18'(r_g1) * 18'(LUMA_G)
                 + 18'(r_b1) * 18'(LUMA_B);
        y        = luma_sum[LUMA_SHIFT +: 8];
        n_r      = cfg.gray_mode ? y : r_r1;
        n_g      = cfg.gray_mode ? y : r_g1;
        n_b      = cfg.gray_mode ? y : r_b1;
        packed_px = {r_a1, n_r, n_g, n_b};
        key_hit  = (cfg.color_key != 32'd0) && (packed_px == cfg.color_key);
        used     = r_seen || r_pm1 || key_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2   <= 1'b0;
            r_seen <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
            if (r_v1) begin
                r_seen <= used && !r_l1;   // cleared after the image's last pixel
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_bo   <= key_hit ? 8'd0 : n_b;
            r_go   <= key_hit ? 8'd0 : n_g;
            r_ro   <= key_hit ? 8'd0 : n_r;
            r_ao   <= key_hit ? 8'd0 : r_a1;
            r_used <= used;
            r_done <= r_l1;
        end
    end

    assign out_ch.valid      = r_v2;
    assign out_ch.blue_out   = r_bo;
    assign out_ch.green_out  = r_go;
    assign out_ch.red_out    = r_ro;
    assign out_ch.alpha_out  = r_ao;
    assign out_ch.alpha_used = r_used;
    assign out_ch.image_done = r_done;
endmodule
`default_nettype wire
